FILE: design/scc_pkg.sv
package scc_pkg;

  localparam int DefMaxGroup = 16;
  localparam int DefMaxRows  = 4096;
  localparam int QueueDepth  = 2;
  localparam int QuotW       = 17;

  localparam logic [2:0] REG_METHOD      = 3'd0;
  localparam logic [2:0] REG_GROUP_SIZE  = 3'd1;
  localparam logic [2:0] REG_AMP_MIN     = 3'd2;
  localparam logic [2:0] REG_AMP_MAX     = 3'd3;
  localparam logic [2:0] REG_MARKER_LOW  = 3'd4;
  localparam logic [2:0] REG_MARKER_HIGH = 3'd5;
  localparam logic [2:0] REG_WIDE        = 3'd6;

  localparam logic [1:0] MODE_RSS  = 2'd0;
  localparam logic [1:0] MODE_MAX  = 2'd1;
  localparam logic [1:0] MODE_PASS = 2'd2;

  typedef struct packed {
    logic [23:0] sample;
    logic        last_of_column;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] row;
    logic        last_pixel;
  } out_item_t;

  typedef struct packed {
    logic [1:0]         method;
    logic [4:0]         group_size;
    logic [23:0]        amp_min;
    logic [23:0]        amp_max;
    logic signed [13:0] marker_low_row;
    logic signed [13:0] marker_high_row;
    logic               wide_markers;
  } cfg_t;

  function automatic logic [7:0] sat8(input logic [10:0] x);
    sat8 = (x > 11'd255) ? 8'd255 : x[7:0];
  endfunction

  // Jet colormap on v in Q1.16 (0..65536), channels truncated.
  function automatic logic [23:0] jet(input logic [16:0] v);
    logic [16:0] t;
    logic [10:0] r, g, b;
    r = '0; g = '0; b = '0; t = '0;
    if (v < 17'd8192) begin
      b = 11'd128 + 11'(v >> 6);
    end else if (v < 17'd24576) begin
      b = 11'd255;
      t = v - 17'd8192;
      g = 11'(t >> 6);
    end else if (v < 17'd40960) begin
      t = v - 17'd24576;
      r = 11'(t >> 6);
      g = 11'd255;
      t = 17'd40960 - v;
      b = 11'(t >> 6);
    end else if (v < 17'd57344) begin
      r = 11'd255;
      t = 17'd57344 - v;
      g = 11'(t >> 6);
    end else begin
      t = 17'd73728 - v;
      r = 11'(t >> 6);
    end
    jet = {sat8(r), sat8(g), sat8(b)};
  endfunction

endpackage

FILE: design/scc_fifo.sv
module scc_fifo
  import scc_pkg::*;
#(
  parameter int W     = 8,
  parameter int DEPTH = QueueDepth
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         full,
  output logic         empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_wr, do_rd;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_rd) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: design/scc_front.sv
module scc_front
  import scc_pkg::*;
#(
  parameter int MAX_GROUP = DefMaxGroup,
  parameter int MAX_ROWS  = DefMaxRows,
  parameter int GW        = $clog2(MAX_GROUP + 1),
  parameter int SUM_W     = 48 + GW,
  parameter int RW        = $clog2(MAX_ROWS),
  parameter int JW        = SUM_W + RW + 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cfg_t          cfg,
  input  logic [GW-1:0] eff_g,
  input  logic          accept,
  input  in_item_t      item,
  output logic          job_push,
  output logic [JW-1:0] job_data
);
  logic [SUM_W-1:0] sum_r, sum_nxt, sum_add;
  logic [23:0]      max_r, max_nxt, max_new;
  logic [GW-1:0]    fill_r, fill_nxt, fill_inc;
  logic [RW-1:0]    row_r, row_nxt;
  logic [47:0]      sq;
  logic [1:0]       mode;
  logic [SUM_W-1:0] val;
  logic             done;

  always_comb begin
    mode     = (cfg.method == 2'd3) ? MODE_PASS : cfg.method;
    sq       = item.sample * item.sample;
    sum_add  = sum_r + SUM_W'(sq);
    max_new  = (item.sample > max_r) ? item.sample : max_r;
    fill_inc = fill_r + 1'b1;
    done     = (fill_inc >= eff_g);
    sum_nxt  = sum_r;
    max_nxt  = max_r;
    fill_nxt = fill_r;
    row_nxt  = row_r;
    job_push = 1'b0;
    unique case (mode)
      MODE_RSS: val = sum_add;
      MODE_MAX: val = SUM_W'(max_new);
      default:  val = SUM_W'(item.sample);
    endcase
    if (accept) begin
      if (mode == MODE_PASS) begin
        job_push = 1'b1;
        sum_nxt  = '0;
        max_nxt  = '0;
        fill_nxt = '0;
      end else if (done) begin
        job_push = 1'b1;
        sum_nxt  = '0;
        max_nxt  = '0;
        fill_nxt = '0;
      end else begin
        sum_nxt  = sum_add;
        max_nxt  = max_new;
        fill_nxt = fill_inc;
      end
      if (job_push && row_r != RW'(MAX_ROWS - 1)) begin
        row_nxt = row_r + 1'b1;
      end
      // End of column: drop any partial group and restart rows.
      if (item.last_of_column) begin
        sum_nxt  = '0;
        max_nxt  = '0;
        fill_nxt = '0;
        row_nxt  = '0;
      end
    end
    job_data = {val, (mode == MODE_RSS), row_r, item.last_of_column};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      max_r  <= '0;
      fill_r <= '0;
      row_r  <= '0;
    end else begin
      sum_r  <= sum_nxt;
      max_r  <= max_nxt;
      fill_r <= fill_nxt;
      row_r  <= row_nxt;
    end
  end

endmodule

FILE: design/scc_back.sv
module scc_back
  import scc_pkg::*;
#(
  parameter int MAX_GROUP = DefMaxGroup,
  parameter int MAX_ROWS  = DefMaxRows,
  parameter int GW        = $clog2(MAX_GROUP + 1),
  parameter int SUM_W     = 48 + GW,
  parameter int RW        = $clog2(MAX_ROWS),
  parameter int JW        = SUM_W + RW + 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cfg_t          cfg,
  input  logic [GW-1:0] eff_g,
  input  logic          job_empty,
  input  logic [JW-1:0] job_data,
  output logic          job_pop,
  input  logic          out_pop,
  output logic          out_empty,
  output out_item_t     out_item
);
  localparam int SQ_W = SUM_W + (SUM_W % 2);
  localparam int TW   = SQ_W / 2;
  localparam int NW   = $clog2(TW + 1);
  localparam int KW   = $clog2(QuotW + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MULG  = 3'd1;
  localparam logic [2:0] S_SQT   = 3'd2;
  localparam logic [2:0] S_SQV   = 3'd3;
  localparam logic [2:0] S_CLAMP = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_COLOR = 3'd6;

  logic [2:0]       st_r, st_nxt;
  logic [SUM_W-1:0] jval_r;
  logic [RW-1:0]    row_r;
  logic             last_r;
  logic [47:0]      am2_r;
  logic [SQ_W-1:0]  x_r;
  logic [TW+1:0]    rem_r, rem_sh, trial;
  logic [TW-1:0]    root_r, top_r, val_r;
  logic [NW-1:0]    ncnt_r;
  logic [TW:0]      dr_r, dsub;
  logic [TW-1:0]    den_r;
  logic [QuotW-1:0] q_r;
  logic [KW-1:0]    kcnt_r;
  logic             out_valid_r;
  out_item_t        out_r;

  logic [TW-1:0]     lo, cv;
  logic              dge;
  logic signed [17:0] rs, ml, mh;
  logic              hit_l, hit_h, can_out;
  logic [23:0]       rgb;

  assign job_pop   = (st_r == S_IDLE) && !job_empty;
  assign out_empty = !out_valid_r;
  assign out_item  = out_r;
  assign can_out   = !out_valid_r || out_pop;

  always_comb begin
    // One step of the bit-pair square root.
    rem_sh = {rem_r[TW-1:0], x_r[SQ_W-1 -: 2]};
    trial  = {root_r, 2'b01};
    lo     = TW'(cfg.amp_min);
    if (val_r < lo) begin
      cv = lo;
    end else if (val_r > top_r) begin
      cv = top_r;
    end else begin
      cv = val_r;
    end
    dge  = (dr_r >= {1'b0, den_r});
    dsub = dge ? (dr_r - {1'b0, den_r}) : dr_r;
    rs   = signed'(18'(row_r));
    ml   = 18'(cfg.marker_low_row);
    mh   = 18'(cfg.marker_high_row);
    if (cfg.wide_markers) begin
      hit_l = (rs >= ml - 18'sd1) && (rs <= ml + 18'sd1);
      hit_h = (rs >= mh - 18'sd1) && (rs <= mh + 18'sd1);
    end else begin
      hit_l = (rs == ml);
      hit_h = (rs == mh);
    end
    rgb = (hit_l || hit_h) ? 24'hFFFFFF : jet(q_r);
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE:  if (!job_empty) st_nxt = job_data[RW+1] ? S_MULG : S_CLAMP;
      S_MULG:  st_nxt = S_SQT;
      S_SQT:   if (ncnt_r == '0) st_nxt = S_SQV;
      S_SQV:   if (ncnt_r == '0) st_nxt = S_CLAMP;
      S_CLAMP: st_nxt = (top_r > lo) ? S_DIV : S_COLOR;
      S_DIV:   if (kcnt_r == KW'(1)) st_nxt = S_COLOR;
      S_COLOR: if (can_out) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      S_IDLE: begin
        jval_r <= job_data[JW-1 -: SUM_W];
        row_r  <= job_data[RW:1];
        last_r <= job_data[0];
        am2_r  <= cfg.amp_max * cfg.amp_max;
        top_r  <= TW'(cfg.amp_max);
        val_r  <= TW'(job_data[JW-SUM_W +: 24]);
      end
      S_MULG: begin
        x_r    <= SQ_W'(am2_r * eff_g);
        rem_r  <= '0;
        root_r <= '0;
        ncnt_r <= NW'(TW);
      end
      S_SQT, S_SQV: begin
        if (ncnt_r == '0) begin
          // Hand the finished root on, load the group value for the next pass.
          if (st_r == S_SQT) begin
            top_r <= root_r;
          end else begin
            val_r <= root_r;
          end
          x_r    <= SQ_W'(jval_r);
          rem_r  <= '0;
          root_r <= '0;
          ncnt_r <= NW'(TW);
        end else begin
          x_r    <= x_r << 2;
          ncnt_r <= ncnt_r - 1'b1;
          if (rem_sh >= trial) begin
            rem_r  <= rem_sh - trial;
            root_r <= {root_r[TW-2:0], 1'b1};
          end else begin
            rem_r  <= rem_sh;
            root_r <= {root_r[TW-2:0], 1'b0};
          end
        end
      end
      S_CLAMP: begin
        dr_r   <= {1'b0, cv - lo};
        den_r  <= top_r - lo;
        q_r    <= '0;
        kcnt_r <= KW'(QuotW);
      end
      S_DIV: begin
        q_r    <= {q_r[QuotW-2:0], dge};
        dr_r   <= {dsub[TW-1:0], 1'b0};
        kcnt_r <= kcnt_r - 1'b1;
      end
      default: begin
      end
    endcase
    if (st_r == S_COLOR && can_out) begin
      out_r <= '{red: rgb[23:16], green: rgb[15:8], blue: rgb[7:0],
                 row: 12'(row_r), last_pixel: last_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_COLOR && can_out) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // The quotient stays within 0..65536; skipping the divider leaves it zero.
  a_q_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_COLOR |-> q_r <= QuotW'(65536)) else $error("quotient out of range");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> st_r == S_IDLE && !job_empty) else $error("pop while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_pop |=> out_valid_r && $stable(out_r))
    else $error("waiting result lost");

endmodule

FILE: design/spectrogram_column_colorizer_top.sv
// Spectrogram column colorizer. Bins (unsigned Q8.16) enter through a queue-
// style port, one per cycle whenever in_full is low; the front end sums the
// squares or takes the maximum over a group, or passes each bin on alone, and
// hands every finished group to a two-entry job queue. The back end turns each
// job into one jet-colormap pixel with its row index: maximum and per-bin modes
// run a 17-step divider, and root-sum-of-squares mode runs two fixed 27-step
// bit-pair square roots before it; the divider is skipped when the scale is
// empty. Bins are taken at one per cycle until the job queue fills; after
// that the back end sets the sustained rate, and a pixel that waits to be
// popped holds the back end. Markers paint white rows. A partial group at the
// end of a column is dropped. Write configuration only while no job is pending.
module spectrogram_column_colorizer_top
  import scc_pkg::*;
#(
  parameter int MAX_GROUP = DefMaxGroup,
  parameter int MAX_ROWS  = DefMaxRows
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  in_item_t    in_item,
  output logic        in_full,
  output logic        out_empty,
  input  logic        out_pop,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);
  localparam int GW    = $clog2(MAX_GROUP + 1);
  localparam int SUM_W = 48 + GW;
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int JW    = SUM_W + RW + 2;

  cfg_t          cfg_r;
  logic [GW-1:0] eff_g;
  logic          job_push, job_pop, job_empty;
  logic [JW-1:0] job_in, job_out;

  // Configuration registers; unknown indexes drop.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{method: MODE_PASS, group_size: 5'd1, amp_min: 24'd0,
                 amp_max: 24'd6553600, marker_low_row: -14'sd2,
                 marker_high_row: -14'sd2, wide_markers: 1'b1};
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_METHOD:      cfg_r.method          <= cfg_wdata[1:0];
        REG_GROUP_SIZE:  cfg_r.group_size      <= cfg_wdata[4:0];
        REG_AMP_MIN:     cfg_r.amp_min         <= cfg_wdata;
        REG_AMP_MAX:     cfg_r.amp_max         <= cfg_wdata;
        REG_MARKER_LOW:  cfg_r.marker_low_row  <= signed'(cfg_wdata[13:0]);
        REG_MARKER_HIGH: cfg_r.marker_high_row <= signed'(cfg_wdata[13:0]);
        REG_WIDE:        cfg_r.wide_markers    <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // Effective group size: zero acts as one, clip at the maximum.
  always_comb begin
    if (cfg_r.group_size == 5'd0) begin
      eff_g = GW'(1);
    end else if (8'(cfg_r.group_size) > 8'(MAX_GROUP)) begin
      eff_g = GW'(MAX_GROUP);
    end else begin
      eff_g = GW'(cfg_r.group_size);
    end
  end

  scc_front #(.MAX_GROUP(MAX_GROUP), .MAX_ROWS(MAX_ROWS)) u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .eff_g(eff_g),
    .accept(in_push && !in_full), .item(in_item),
    .job_push(job_push), .job_data(job_in)
  );

  scc_fifo #(.W(JW), .DEPTH(QueueDepth)) u_queue (
    .clk(clk), .rst_n(rst_n), .wr_en(job_push), .wr_data(job_in),
    .rd_en(job_pop), .rd_data(job_out), .full(in_full), .empty(job_empty)
  );

  scc_back #(.MAX_GROUP(MAX_GROUP), .MAX_ROWS(MAX_ROWS)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .eff_g(eff_g),
    .job_empty(job_empty), .job_data(job_out), .job_pop(job_pop),
    .out_pop(out_pop), .out_empty(out_empty), .out_item(out_item)
  );

endmodule
